// ===== rtl/sms_pkg.sv =====
// shared types and sequencer state codes for the stable merge sorter
package sms_pkg;

    typedef logic [2:0] t_state;

    localparam t_state S_IDLE     = 3'd0;
    localparam t_state S_RUN_INIT = 3'd1;
    localparam t_state S_FETCH    = 3'd2;
    localparam t_state S_MERGE    = 3'd3;
    localparam t_state S_OUT_RD   = 3'd4;
    localparam t_state S_OUT_EMIT = 3'd5;

    localparam int unsigned PORT_WIDTH = 32;

endpackage

// ===== rtl/stable_merge_sorter.sv =====
// stable bottom-up merge sorter: batch buffer, ping-pong merge passes, sorted readout
//
//  channel   | signals                                      | direction | flow
//  ----------+----------------------------------------------+-----------+------------------
//  input     | start, busy, i_value, i_last_item            | in        | start & !busy
//  result    | o_strobe, o_sorted_value, o_last_result,     | out       | one-cycle strobe
//            | o_dropped                                    |           |
//
// loading accepts one beat per cycle; busy stays low until the beat marked last
// sorting n values takes ceil(log2 n) merge passes with a fetch and a merge state per value,
// set by the single compare unit and the registered read of the two-port banks
// readout steps through a read state, then a strobe state, for each value
// synchronous active-low reset clears the sequencer, count, overflow flag, r_src, r_lo and r_w only
// the receiver cannot stall: each result is shown for exactly one cycle
module stable_merge_sorter
    import sms_pkg::*;
#(
    parameter int unsigned MAX_ELEMENTS = 64,
    parameter int unsigned VALUE_WIDTH  = 32
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         start,
    output logic                         busy,
    input  logic signed [PORT_WIDTH-1:0] i_value,
    input  logic                         i_last_item,
    output logic                         o_strobe,
    output logic signed [PORT_WIDTH-1:0] o_sorted_value,
    output logic                         o_last_result,
    output logic                         o_dropped
);

    localparam int unsigned AW = (MAX_ELEMENTS > 1) ? $clog2(MAX_ELEMENTS) : 1;
    localparam int unsigned CW = $clog2(MAX_ELEMENTS + 1);
    localparam int unsigned SW = CW + 2;

    typedef logic [CW-1:0]          t_cnt;
    typedef logic [SW-1:0]          t_sum;
    typedef logic [VALUE_WIDTH-1:0] t_val;

    // two banks, merge passes alternate between them
    t_val mem_a [MAX_ELEMENTS];
    t_val mem_b [MAX_ELEMENTS];

    t_state     r_state, n_state;
    t_cnt       r_count, n_count;
    logic       r_ovf, n_ovf;
    logic       r_src, n_src;
    t_cnt       r_lo, n_lo;
    logic [CW:0] r_w, n_w;
    t_cnt       r_a, n_a;
    t_cnt       r_b, n_b;
    t_cnt       r_mid, n_mid;
    t_cnt       r_hi, n_hi;
    t_cnt       r_k, n_k;
    t_val       r_rd_a, r_rd_b;

    logic       wr_a_en, wr_b_en;
    t_cnt       wr_addr;
    t_val       wr_data;
    logic       take_a;
    t_sum       lo_plus_w, lo_plus_2w, two_w;
    logic       in_accept;

    assign in_accept  = start && !busy;
    assign busy       = (r_state != S_IDLE);
    assign two_w      = {r_w, 1'b0};
    assign lo_plus_w  = SW'(r_lo) + SW'(r_w);
    assign lo_plus_2w = SW'(r_lo) + two_w;

    // left run wins ties so equal values keep arrival order
    assign take_a = (r_a < r_mid) &&
                    ((r_b >= r_hi) || ($signed(r_rd_a) <= $signed(r_rd_b)));

    always_comb begin
        n_state = r_state;
        n_count = r_count;
        n_ovf   = r_ovf;
        n_src   = r_src;
        n_lo    = r_lo;
        n_w     = r_w;
        n_a     = r_a;
        n_b     = r_b;
        n_mid   = r_mid;
        n_hi    = r_hi;
        n_k     = r_k;
        wr_a_en = 1'b0;
        wr_b_en = 1'b0;
        wr_addr = r_k;
        wr_data = take_a ? r_rd_a : r_rd_b;

        unique case (r_state)
            S_IDLE: begin
                if (in_accept) begin
                    if (r_count < CW'(MAX_ELEMENTS)) begin
                        wr_a_en = 1'b1;
                        wr_addr = r_count;
                        wr_data = VALUE_WIDTH'($unsigned(i_value));
                        n_count = r_count + 1'b1;
                    end else begin
                        n_ovf = 1'b1;
                    end
                    if (i_last_item) begin
                        n_src = 1'b0;
                        n_lo  = '0;
                        n_w   = (CW + 1)'(1);
                        n_k   = '0;
                        n_a   = '0;
                        // a single value needs no pass
                        if (r_count == '0) begin
                            n_state = S_OUT_RD;
                        end else begin
                            n_state = S_RUN_INIT;
                        end
                    end
                end
            end
            S_RUN_INIT: begin
                n_a   = r_lo;
                n_k   = r_lo;
                n_mid = (lo_plus_w  < SW'(r_count)) ? CW'(lo_plus_w)  : r_count;
                n_hi  = (lo_plus_2w < SW'(r_count)) ? CW'(lo_plus_2w) : r_count;
                n_b   = (lo_plus_w  < SW'(r_count)) ? CW'(lo_plus_w)  : r_count;
                n_state = S_FETCH;
            end
            S_FETCH: begin
                n_state = S_MERGE;
            end
            S_MERGE: begin
                wr_a_en = r_src;
                wr_b_en = !r_src;
                if (take_a) begin
                    n_a = r_a + 1'b1;
                end else begin
                    n_b = r_b + 1'b1;
                end
                n_k = r_k + 1'b1;
                if ((r_k + 1'b1) == r_hi) begin
                    if (lo_plus_2w >= SW'(r_count)) begin
                        // pass done, result now sits in the other bank
                        n_src = !r_src;
                        n_lo  = '0;
                        n_w   = {r_w[CW-1:0], 1'b0};
                        if (two_w >= SW'(r_count)) begin
                            n_k     = '0;
                            n_a     = '0;
                            n_state = S_OUT_RD;
                        end else begin
                            n_state = S_RUN_INIT;
                        end
                    end else begin
                        n_lo    = CW'(lo_plus_2w);
                        n_state = S_RUN_INIT;
                    end
                end else begin
                    n_state = S_FETCH;
                end
            end
            S_OUT_RD: begin
                n_state = S_OUT_EMIT;
            end
            S_OUT_EMIT: begin
                if ((r_k + 1'b1) == r_count) begin
                    n_count = '0;
                    n_ovf   = 1'b0;
                    n_lo    = '0;
                    n_w     = (CW + 1)'(1);
                    n_state = S_IDLE;
                end else begin
                    n_k     = r_k + 1'b1;
                    n_a     = r_k + 1'b1;
                    n_state = S_OUT_RD;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
            r_ovf   <= 1'b0;
            r_src   <= 1'b0;
            r_lo    <= '0;
            r_w     <= (CW + 1)'(1);
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_ovf   <= n_ovf;
            r_src   <= n_src;
            r_lo    <= n_lo;
            r_w     <= n_w;
        end
    end

    always_ff @(posedge i_clk) begin
        r_a   <= n_a;
        r_b   <= n_b;
        r_mid <= n_mid;
        r_hi  <= n_hi;
        r_k   <= n_k;
    end

    // bank writes, one address per bank per cycle
    always_ff @(posedge i_clk) begin
        if (wr_a_en) begin
            mem_a[wr_addr[AW-1:0]] <= wr_data;
        end
        if (wr_b_en) begin
            mem_b[wr_addr[AW-1:0]] <= wr_data;
        end
    end

    // registered reads at the two run heads of the source bank
    always_ff @(posedge i_clk) begin
        r_rd_a <= r_src ? mem_b[r_a[AW-1:0]] : mem_a[r_a[AW-1:0]];
        r_rd_b <= r_src ? mem_b[r_b[AW-1:0]] : mem_a[r_b[AW-1:0]];
    end

    assign o_strobe       = (r_state == S_OUT_EMIT);
    assign o_sorted_value = PORT_WIDTH'(r_rd_a);
    assign o_last_result  = o_strobe && ((r_k + 1'b1) == r_count);
    assign o_dropped      = o_last_result && r_ovf;

    a_strobe_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> busy)
        else $error("result strobe outside a busy period");

    a_last_frees: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_last_result |=> !busy)
        else $error("block still busy after final result");

    a_dropped_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_dropped |-> o_last_result)
        else $error("dropped flag on a result that is not the last");

    a_merge_live: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_MERGE) |-> ((r_a < r_mid) || (r_b < r_hi)))
        else $error("merge step with both runs exhausted");

endmodule

// ===== tb/stable_merge_sorter_tb.sv =====
// self-checking testbench for the stable merge sorter: directed table, then random batches
`timescale 1ns / 100ps

module stable_merge_sorter_tb;
    import sms_pkg::*;

    localparam int unsigned MAX_ELEMENTS = 64;
    localparam int unsigned VALUE_WIDTH  = 32;
    localparam int          RANDOM_BEATS = 500;
    localparam int          TAIL_CYCLES  = 64;
    localparam int          CYCLE_LIMIT  = 400000;

    typedef logic signed [PORT_WIDTH-1:0] t_value;

    typedef struct packed {
        t_value value;
        logic   last;
        logic   dropped;
    } t_sorted_beat;

    typedef struct packed {
        t_value       value;
        logic         last;
        logic         typed;
        t_sorted_beat expect_beat;
    } t_directed_row;

    localparam int DIRECTED_ROWS = 23;

    // typed rows are single-value batches sent while nothing is held
    localparam t_directed_row DIRECTED_TABLE [DIRECTED_ROWS] = '{
        '{32'sh7fffffff, 1'b1, 1'b1, '{32'sh7fffffff, 1'b1, 1'b0}},
        '{32'sh80000000, 1'b1, 1'b1, '{32'sh80000000, 1'b1, 1'b0}},
        '{32'sh00000000, 1'b1, 1'b1, '{32'sh00000000, 1'b1, 1'b0}},
        '{32'shffffffff, 1'b1, 1'b1, '{32'shffffffff, 1'b1, 1'b0}},
        '{32'sh00000005, 1'b0, 1'b0, '0},
        '{32'shfffffffd, 1'b0, 1'b0, '0},
        '{32'sh00000005, 1'b0, 1'b0, '0},
        '{32'sh80000000, 1'b0, 1'b0, '0},
        '{32'sh7fffffff, 1'b1, 1'b0, '0},
        '{32'sh00000003, 1'b0, 1'b0, '0},
        '{32'sh00000002, 1'b0, 1'b0, '0},
        '{32'sh00000001, 1'b1, 1'b0, '0},
        '{32'sh00000001, 1'b0, 1'b0, '0},
        '{32'sh00000002, 1'b0, 1'b0, '0},
        '{32'sh00000003, 1'b1, 1'b0, '0},
        '{32'sh00000007, 1'b0, 1'b0, '0},
        '{32'sh00000007, 1'b0, 1'b0, '0},
        '{32'sh00000007, 1'b0, 1'b0, '0},
        '{32'shfffffff9, 1'b0, 1'b0, '0},
        '{32'sh00000007, 1'b0, 1'b0, '0},
        '{32'shfffffff9, 1'b1, 1'b0, '0},
        '{32'shffffffff, 1'b0, 1'b0, '0},
        '{32'sh00000000, 1'b1, 1'b0, '0}
    };

    logic         i_clk;
    logic         i_rst_n;
    logic         start;
    logic         busy;
    t_value       i_value;
    logic         i_last_item;
    logic         o_strobe;
    t_value       o_sorted_value;
    logic         o_last_result;
    logic         o_dropped;

    logic         row_typed;
    t_sorted_beat row_expect;

    t_value       batch_held[$];
    logic         batch_overflow;
    t_sorted_beat pending_sorted[$];
    t_sorted_beat got_beat;
    int           fail_count;
    int           beats_sent;
    int           cycle_count;

    stable_merge_sorter #(
        .MAX_ELEMENTS(MAX_ELEMENTS),
        .VALUE_WIDTH (VALUE_WIDTH)
    ) dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .start         (start),
        .busy          (busy),
        .i_value       (i_value),
        .i_last_item   (i_last_item),
        .o_strobe      (o_strobe),
        .o_sorted_value(o_sorted_value),
        .o_last_result (o_last_result),
        .o_dropped     (o_dropped)
    );

    initial i_clk = 1'b0;
    always #1 i_clk = ~i_clk;

    // hold the beat, sort on the last one with a stable insertion sort
    function automatic void predict_sorted_batch(t_value v, logic lst);
        t_value       ordered[$];
        t_value       key;
        t_sorted_beat beat;
        int           i;
        int           j;
        if (batch_held.size() < MAX_ELEMENTS) begin
            batch_held.push_back(v);
        end else begin
            batch_overflow = 1'b1;
        end
        if (!lst) return;
        ordered = batch_held;
        for (i = 1; i < ordered.size(); i++) begin
            key = ordered[i];
            j = i - 1;
            // strict compare so equal values never pass each other
            while (j >= 0 && ordered[j] > key) begin
                ordered[j + 1] = ordered[j];
                j--;
            end
            ordered[j + 1] = key;
        end
        for (i = 0; i < ordered.size(); i++) begin
            beat.value   = ordered[i];
            beat.last    = (i == ordered.size() - 1);
            beat.dropped = beat.last && batch_overflow;
            pending_sorted.push_back(beat);
        end
        batch_held.delete();
        batch_overflow = 1'b0;
    endfunction

    // accepted input beats
    always @(posedge i_clk) begin
        if (i_rst_n && start === 1'b1 && busy === 1'b0) begin
            if (row_typed) begin
                batch_held.delete();
                batch_overflow = 1'b0;
                pending_sorted.push_back(row_expect);
            end else begin
                predict_sorted_batch(i_value, i_last_item);
            end
        end
    end

    // result beats, compared against the oldest expectation
    always @(posedge i_clk) begin
        if (i_rst_n && o_strobe !== 1'b0) begin
            if (pending_sorted.size() == 0) begin
                $error("unexpected result beat: sorted_value %0d", o_sorted_value);
                fail_count++;
            end else begin
                got_beat = pending_sorted.pop_front();
                if (o_sorted_value !== got_beat.value) begin
                    $error("sorted_value expected %0d actual %0d", got_beat.value,
                           o_sorted_value);
                    fail_count++;
                end
                if (o_last_result !== got_beat.last) begin
                    $error("last_result expected %0b actual %0b", got_beat.last,
                           o_last_result);
                    fail_count++;
                end
                if (o_dropped !== got_beat.dropped) begin
                    $error("dropped expected %0b actual %0b", got_beat.dropped, o_dropped);
                    fail_count++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    task automatic send_beat(input t_value v, input logic lst, input logic typed,
                             input t_sorted_beat typed_beat, input int gap);
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        start       <= 1'b1;
        i_value     <= v;
        i_last_item <= lst;
        row_typed   <= typed;
        row_expect  <= typed_beat;
        do @(posedge i_clk); while (busy !== 1'b0);
        beats_sent++;
    endtask

    function automatic t_value pick_value(input int mode);
        t_value v;
        case (mode)
            0: v = $urandom;
            // narrow range gives plenty of equal keys
            1: v = $signed($urandom_range(0, 15)) - 8;
            default: begin
                case ($urandom_range(0, 4))
                    0: v = 32'sh80000000;
                    1: v = 32'sh7fffffff;
                    2: v = '0;
                    3: v = -1;
                    default: v = $urandom;
                endcase
            end
        endcase
        return v;
    endfunction

    task automatic send_batch(input int len);
        int  mode;
        bit  burst;
        int  k;
        mode  = $urandom_range(0, 2);
        burst = ($urandom_range(0, 2) == 0);
        for (k = 0; k < len; k++) begin
            send_beat(pick_value(mode), k == len - 1, 1'b0, '0,
                      burst ? 0 : $urandom_range(0, 12));
        end
    endtask

    initial begin
        int r;
        int len;
        int batch_no;
        i_rst_n        = 1'b0;
        start          = 1'b0;
        i_value        = '0;
        i_last_item    = 1'b0;
        row_typed      = 1'b0;
        row_expect     = '0;
        batch_overflow = 1'b0;
        fail_count     = 0;
        beats_sent     = 0;
        cycle_count    = 0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        for (r = 0; r < DIRECTED_ROWS; r++) begin
            send_beat(DIRECTED_TABLE[r].value, DIRECTED_TABLE[r].last,
                      DIRECTED_TABLE[r].typed, DIRECTED_TABLE[r].expect_beat,
                      $urandom_range(0, 12));
        end

        // full buffer, then beats past the end of it
        send_batch(MAX_ELEMENTS);
        send_batch(MAX_ELEMENTS + 1);
        send_batch(MAX_ELEMENTS + 6);

        batch_no   = 0;
        while (beats_sent < RANDOM_BEATS) begin
            r = $urandom_range(0, 19);
            if (r == 0) len = $urandom_range(MAX_ELEMENTS - 4, MAX_ELEMENTS + 6);
            else if (r < 4) len = $urandom_range(17, 40);
            else len = $urandom_range(1, 16);
            send_batch(len);
            batch_no++;
            if (batch_no == 5) begin
                // hold off until every result of the earlier batches is out
                start <= 1'b0;
                do @(posedge i_clk); while (pending_sorted.size() != 0);
            end
        end

        start <= 1'b0;
        do @(posedge i_clk); while (pending_sorted.size() != 0);
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (pending_sorted.size() != 0 || batch_held.size() != 0) begin
            $error("%0d result beats never arrived", pending_sorted.size());
            fail_count++;
        end
        if (fail_count == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
rtl/sms_pkg.sv
rtl/stable_merge_sorter.sv
tb/stable_merge_sorter_tb.sv
